### rtl/lbm_pkg.sv
// Shared types and constants for the D2Q5 reaction-collision block.
`timescale 1ns / 1ps

package lbm_pkg;

  localparam int DATA_W  = 32;
  localparam int LANES   = 5;
  localparam int IN_W    = 256;
  localparam int OUT_W   = 160;
  localparam int USER_W  = 2;
  localparam int CADDR_W = 3;

  typedef enum logic [CADDR_W-1:0] {
    CFG_INV_TAU         = 3'd0,
    CFG_SWITCH_OFF_TIME = 3'd1,
    CFG_DECAY_RATE      = 3'd2,
    CFG_TURNOVER_RATE   = 3'd3,
    CFG_PRODUCTION_RATE = 3'd4
  } cfg_idx_t;

  typedef enum logic [1:0] {
    RK_PRODUCE,
    RK_TURNOVER,
    RK_DECAY
  } react_kind_t;

  localparam logic [1:0] CT_CELL   = 2'd1;
  localparam logic [1:0] CT_SOURCE = 2'd2;

  localparam logic [30:0] RST_INV_TAU         = 31'd268435456;
  localparam logic [31:0] RST_SWITCH_OFF_TIME = 32'd5000;
  localparam logic [30:0] RST_DECAY_RATE      = 31'd268435;
  localparam logic [30:0] RST_TURNOVER_RATE   = 31'd1342177;
  localparam logic [30:0] RST_PRODUCTION_RATE = 31'd26844;

  // floor(x / 3) = (x * RECIP3) >> 33 for every x below 2**32.
  localparam logic [31:0] RECIP3 = 32'hAAAAAAAB;
  // floor(2**24 / 3); 2**24 leaves a remainder of one.
  localparam logic [22:0] K24 = 23'd5592405;

endpackage

### rtl/lbm_d2q5_reaction_collide.sv
// D2Q5 BGK collision with reaction term for one lattice node per word.
// Seven register stages lie between input acceptance and m_tvalid, built from
// multiplies, shifts, divide-by-three reciprocal products and saturating adds.
// Throughput: one word per cycle while m_tready is high; each stage advances whenever its successor has room.
// Reset clears all stage valid bits and returns the configuration registers to their defaults.
`timescale 1ns / 1ps

module lbm_d2q5_reaction_collide
  import lbm_pkg::*;
#(
  parameter int FRAC_BITS = 28
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 s_tvalid,
  output logic                 s_tready,
  // dist_rest, dist_east, dist_north, dist_west, dist_south, vel_x, vel_y, iteration
  input  logic [IN_W-1:0]      s_tdata,
  // cell_type
  input  logic [USER_W-1:0]    s_tuser,
  output logic                 m_tvalid,
  input  logic                 m_tready,
  // out_rest, out_east, out_north, out_west, out_south
  output logic [OUT_W-1:0]     m_tdata,
  input  logic                 cfg_we,
  input  logic [CADDR_W-1:0]   cfg_addr,
  input  logic [DATA_W-1:0]    cfg_wdata
);

  localparam int RW = 64 - FRAC_BITS;
  localparam int HW = RW - 24;
  localparam int SW = 66 - FRAC_BITS;
  localparam logic signed [34:0] ONE = 35'sd1 <<< FRAC_BITS;

  function automatic logic signed [31:0] sat32(input logic signed [SW-1:0] x);
    logic [SW-32:0] top;
    top = x[SW-1:31];
    if ((top == '0) || (top == '1)) begin
      return x[31:0];
    end else if (x[SW-1]) begin
      return 32'sh80000000;
    end else begin
      return 32'sh7FFFFFFF;
    end
  endfunction

  logic [30:0] inv_tau;
  logic [31:0] switch_off_time;
  logic [30:0] decay_rate;
  logic [30:0] turnover_rate;
  logic [30:0] production_rate;

  always_ff @(posedge clk) begin
    if (rst) begin
      inv_tau         <= RST_INV_TAU;
      switch_off_time <= RST_SWITCH_OFF_TIME;
      decay_rate      <= RST_DECAY_RATE;
      turnover_rate   <= RST_TURNOVER_RATE;
      production_rate <= RST_PRODUCTION_RATE;
    end else if (cfg_we) begin
      case (cfg_addr)
        CFG_INV_TAU:         inv_tau         <= cfg_wdata[30:0];
        CFG_SWITCH_OFF_TIME: switch_off_time <= cfg_wdata;
        CFG_DECAY_RATE:      decay_rate      <= cfg_wdata[30:0];
        CFG_TURNOVER_RATE:   turnover_rate   <= cfg_wdata[30:0];
        CFG_PRODUCTION_RATE: production_rate <= cfg_wdata[30:0];
        default: ;
      endcase
    end
  end

  logic [7:1] v;
  logic [7:1] en;

  always_comb begin
    en[7] = !v[7] || m_tready;
    for (int k = 6; k >= 1; k--) begin
      en[k] = !v[k] || en[k+1];
    end
  end

  assign s_tready = en[1];
  assign m_tvalid = v[7];

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else begin
      if (en[1]) begin
        v[1] <= s_tvalid;
      end
      for (int k = 2; k <= 7; k++) begin
        if (en[k]) begin
          v[k] <= v[k-1];
        end
      end
    end
  end

  // Stage 1: concentration, velocity factors, reaction kind.
  logic signed [31:0] in_f [LANES];
  logic signed [31:0] ux, uy;
  logic [31:0]        iter;
  logic signed [34:0] sum35, tx, ty;
  react_kind_t        kind;

  always_comb begin
    for (int i = 0; i < LANES; i++) begin
      in_f[i] = s_tdata[32*i +: 32];
    end
    ux    = s_tdata[191:160];
    uy    = s_tdata[223:192];
    iter  = s_tdata[255:224];
    sum35 = 35'(in_f[0]) + 35'(in_f[1]) + 35'(in_f[2]) + 35'(in_f[3]) + 35'(in_f[4]);
    tx    = (35'(ux) <<< 1) + 35'(ux);
    ty    = (35'(uy) <<< 1) + 35'(uy);
    if ((s_tuser == CT_SOURCE) && (iter < switch_off_time)) begin
      kind = RK_PRODUCE;
    end else if (s_tuser == CT_CELL) begin
      kind = RK_TURNOVER;
    end else begin
      kind = RK_DECAY;
    end
  end

  logic signed [31:0] s1_f [LANES];
  logic signed [31:0] s1_fac [4];
  logic signed [31:0] s1_c;
  react_kind_t        s1_kind;

  always_ff @(posedge clk) begin
    if (en[1]) begin
      for (int i = 0; i < LANES; i++) begin
        s1_f[i] <= in_f[i];
      end
      s1_c      <= sat32(SW'(sum35));
      s1_fac[0] <= sat32(SW'(ONE + tx));
      s1_fac[1] <= sat32(SW'(ONE + ty));
      s1_fac[2] <= sat32(SW'(ONE - tx));
      s1_fac[3] <= sat32(SW'(ONE - ty));
      s1_kind   <= kind;
    end
  end

  // Stage 2: |C| / 3 reciprocal product and rate * C.
  logic signed [31:0] rate_s;
  logic [31:0]        cabs;

  always_comb begin
    case (s1_kind)
      RK_PRODUCE, RK_TURNOVER: rate_s = {1'b0, turnover_rate};
      default:                 rate_s = {1'b0, decay_rate};
    endcase
    cabs = s1_c[31] ? (~s1_c + 32'd1) : s1_c;
  end

  logic signed [31:0] s2_f [LANES];
  logic signed [31:0] s2_fac [4];
  logic               s2_cneg;
  logic [63:0]        s2_cq;
  logic signed [63:0] s2_rx;
  logic               s2_padd;

  always_ff @(posedge clk) begin
    if (en[2]) begin
      s2_f    <= s1_f;
      s2_fac  <= s1_fac;
      s2_cneg <= s1_c[31];
      s2_cq   <= cabs * RECIP3;
      s2_rx   <= rate_s * s1_c;
      s2_padd <= (s1_kind == RK_PRODUCE);
    end
  end

  // Stage 3: signed C/3 and C/6, reaction term R.
  logic [30:0]        q3;
  logic signed [31:0] q3s, q6s;
  logic signed [63:0] pz, r64;

  always_comb begin
    q3  = s2_cq[63:33];
    q3s = $signed({1'b0, q3});
    q6s = $signed({2'b00, q3[30:1]});
    pz  = s2_padd ? $signed({33'd0, production_rate}) : 64'sd0;
    r64 = pz - (s2_rx >>> FRAC_BITS);
  end

  logic signed [31:0]  s3_f [LANES];
  logic signed [31:0]  s3_fac [4];
  logic signed [31:0]  s3_w0, s3_w1;
  logic signed [RW-1:0] s3_r;

  always_ff @(posedge clk) begin
    if (en[3]) begin
      s3_f   <= s2_f;
      s3_fac <= s2_fac;
      s3_w0  <= s2_cneg ? -q3s : q3s;
      s3_w1  <= s2_cneg ? -q6s : q6s;
      s3_r   <= r64[RW-1:0];
    end
  end

  // Stage 4: equilibrium products, |R| split for the divide by three.
  logic [RW-1:0] rbits, ra;

  always_comb begin
    rbits = s3_r;
    ra    = s3_r[RW-1] ? (~rbits + RW'(1)) : rbits;
  end

  logic signed [31:0] s4_f [LANES];
  logic signed [31:0] s4_w0;
  logic signed [63:0] s4_pe [4];
  logic               s4_rneg;
  logic [HW-1:0]      s4_ahi;
  logic [24:0]        s4_lsum;

  always_ff @(posedge clk) begin
    if (en[4]) begin
      s4_f  <= s3_f;
      s4_w0 <= s3_w0;
      for (int i = 0; i < 4; i++) begin
        s4_pe[i] <= s3_w1 * s3_fac[i];
      end
      s4_rneg <= s3_r[RW-1];
      s4_ahi  <= ra[RW-1:24];
      s4_lsum <= 25'(ra[RW-1:24]) + 25'(ra[23:0]);
    end
  end

  // Stage 5: equilibrium shift and saturation, partial quotients of |R| / 3.
  logic signed [63:0] eqv [4];

  always_comb begin
    for (int i = 0; i < 4; i++) begin
      eqv[i] = s4_pe[i] >>> FRAC_BITS;
    end
  end

  logic signed [31:0] s5_f [LANES];
  logic signed [31:0] s5_eq [LANES];
  logic               s5_rneg;
  logic [RW-2:0]      s5_hik;
  logic [56:0]        s5_sq;

  always_ff @(posedge clk) begin
    if (en[5]) begin
      s5_f     <= s4_f;
      s5_eq[0] <= s4_w0;
      for (int i = 0; i < 4; i++) begin
        s5_eq[i+1] <= sat32(eqv[i][SW-1:0]);
      end
      s5_rneg <= s4_rneg;
      s5_hik  <= s4_ahi * K24;
      s5_sq   <= s4_lsum * RECIP3;
    end
  end

  // Stage 6: relaxation products, |R| / 3 assembled.
  logic signed [31:0] its;

  assign its = $signed({1'b0, inv_tau});

  logic signed [31:0] s6_f [LANES];
  logic signed [63:0] s6_fit [LANES];
  logic signed [63:0] s6_eit [LANES];
  logic               s6_rneg;
  logic [RW-1:0]      s6_rq;

  always_ff @(posedge clk) begin
    if (en[6]) begin
      s6_f <= s5_f;
      for (int i = 0; i < LANES; i++) begin
        s6_fit[i] <= s5_f[i] * its;
        s6_eit[i] <= s5_eq[i] * its;
      end
      s6_rneg <= s5_rneg;
      s6_rq   <= {1'b0, s5_hik} + RW'(s5_sq[56:33]);
    end
  end

  // Stage 7: relaxation sum and saturation.
  logic signed [63:0]   fsh64 [LANES];
  logic signed [63:0]   esh64 [LANES];
  logic signed [SW-1:0] fsh [LANES];
  logic signed [SW-1:0] esh [LANES];
  logic signed [SW-1:0] fx [LANES];
  logic signed [SW-1:0] vsum [LANES];
  logic signed [SW-1:0] rq0, rq1, r0, r1;

  always_comb begin
    rq0 = SW'(s6_rq);
    rq1 = SW'(s6_rq >> 1);
    r0  = s6_rneg ? -rq0 : rq0;
    r1  = s6_rneg ? -rq1 : rq1;
    for (int i = 0; i < LANES; i++) begin
      fsh64[i] = s6_fit[i] >>> FRAC_BITS;
      esh64[i] = s6_eit[i] >>> FRAC_BITS;
      fsh[i]   = fsh64[i][SW-1:0];
      esh[i]   = esh64[i][SW-1:0];
      fx[i]    = SW'(s6_f[i]);
      vsum[i]  = fx[i] - fsh[i] + esh[i] + ((i == 0) ? r0 : r1);
    end
  end

  logic signed [31:0] s7_n [LANES];

  always_ff @(posedge clk) begin
    if (en[7]) begin
      for (int i = 0; i < LANES; i++) begin
        s7_n[i] <= sat32(vsum[i]);
      end
    end
  end

  assign m_tdata = {s7_n[2], s7_n[1], s7_n[4], s7_n[3], s7_n[0]};

  a_accept_fills_stage1 : assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready) |=> v[1])
    else $error("accepted word did not enter stage 1");

  a_full_stall_blocks_input : assert property (@(posedge clk) disable iff (rst)
    ((&v) && !m_tready) |-> !s_tready)
    else $error("input accepted while the full pipeline is stalled");

  a_drain_empties_output : assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tready && !v[6]) |=> !m_tvalid)
    else $error("output word repeated after it was taken");

endmodule

### test/lbm_d2q5_reaction_collide_test.sv
// Self-checking testbench for the D2Q5 reaction-collision block under random stream pressure.
`timescale 1ns / 1ps

module lbm_d2q5_reaction_collide_test;
  import lbm_pkg::*;

  localparam int FRAC_BITS = 28;
  localparam int SETTLE = 16;
  localparam logic [31:0] ONE = 32'h1000_0000;
  localparam int VMAX = 80530636;
  localparam logic [1:0] CT_PLAIN = 2'd0;
  localparam logic [1:0] CT_OTHER = 2'd3;

  typedef struct packed {
    logic [31:0]        iteration;
    logic signed [31:0] vel_y;
    logic signed [31:0] vel_x;
    logic signed [31:0] south;
    logic signed [31:0] west;
    logic signed [31:0] north;
    logic signed [31:0] east;
    logic signed [31:0] rest;
  } node_t;

  class collide_checker;
    logic [30:0] inv_tau = RST_INV_TAU;
    logic [31:0] switch_off_time = RST_SWITCH_OFF_TIME;
    logic [30:0] decay_rate = RST_DECAY_RATE;
    logic [30:0] turnover_rate = RST_TURNOVER_RATE;
    logic [30:0] production_rate = RST_PRODUCTION_RATE;
    logic [OUT_W-1:0] pending_nodes[$];
    string lane_name[LANES] = '{"out_rest", "out_east", "out_north", "out_west", "out_south"};
    int errors = 0;

    function void set_reg(cfg_idx_t idx, logic [31:0] v);
      case (idx)
        CFG_INV_TAU:         inv_tau = v[30:0];
        CFG_SWITCH_OFF_TIME: switch_off_time = v;
        CFG_DECAY_RATE:      decay_rate = v[30:0];
        CFG_TURNOVER_RATE:   turnover_rate = v[30:0];
        CFG_PRODUCTION_RATE: production_rate = v[30:0];
        default: ;
      endcase
    endfunction

    function longint clip32(longint v);
      if (v > 64'sd2147483647) return 64'sd2147483647;
      if (v < -64'sd2147483648) return -64'sd2147483648;
      return v;
    endfunction

    // Exact product scaled back by the fraction width, rounding toward minus infinity.
    function longint fmul(longint a, longint b);
      return (a * b) >>> FRAC_BITS;
    endfunction

    function longint relax(longint f, longint eq, longint it, longint rw);
      return clip32(f - fmul(f, it) + fmul(eq, it) + rw);
    endfunction

    function logic [OUT_W-1:0] collide_node(node_t n, logic [1:0] ct);
      longint f0, fe, fn, fw, fs, ux, uy, one, it, c, w0, w1;
      longint eq_e, eq_n, eq_w, eq_s, r, r0, r1, n0, ne, nn, nw, ns;
      f0 = $signed(n.rest);
      fe = $signed(n.east);
      fn = $signed(n.north);
      fw = $signed(n.west);
      fs = $signed(n.south);
      ux = $signed(n.vel_x);
      uy = $signed(n.vel_y);
      one = longint'(1) << FRAC_BITS;
      it = inv_tau;
      c = clip32(f0 + fe + fn + fw + fs);
      w0 = c / 3;
      w1 = c / 6;
      eq_e = clip32(fmul(w1, clip32(one + 3 * ux)));
      eq_n = clip32(fmul(w1, clip32(one + 3 * uy)));
      eq_w = clip32(fmul(w1, clip32(one - 3 * ux)));
      eq_s = clip32(fmul(w1, clip32(one - 3 * uy)));
      if (ct == CT_SOURCE && n.iteration < switch_off_time) begin
        r = production_rate;
        r = r - fmul(turnover_rate, c);
      end else if (ct == CT_CELL) begin
        r = -fmul(turnover_rate, c);
      end else begin
        r = -fmul(decay_rate, c);
      end
      r0 = r / 3;
      r1 = r / 6;
      n0 = relax(f0, w0, it, r0);
      ne = relax(fe, eq_e, it, r1);
      nn = relax(fn, eq_n, it, r1);
      nw = relax(fw, eq_w, it, r1);
      ns = relax(fs, eq_s, it, r1);
      // East/west and north/south leave swapped.
      return {nn[31:0], ne[31:0], ns[31:0], nw[31:0], n0[31:0]};
    endfunction

    function void note_node(node_t n, logic [1:0] ct);
      pending_nodes.push_back(collide_node(n, ct));
    endfunction

    function void check_word(logic [OUT_W-1:0] got);
      logic [OUT_W-1:0] want;
      if (pending_nodes.size() == 0) begin
        $display("%0t: unexpected word, expected none, actual %h", $time, got);
        errors++;
        return;
      end
      want = pending_nodes.pop_front();
      for (int k = 0; k < LANES; k++) begin
        if (got[32*k +: 32] !== want[32*k +: 32]) begin
          $display("%0t: %s expected %h actual %h", $time, lane_name[k],
                   want[32*k +: 32], got[32*k +: 32]);
          errors++;
        end
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic s_tvalid = 1'b0;
  logic s_tready;
  logic [IN_W-1:0] s_tdata = '0;
  logic [USER_W-1:0] s_tuser = '0;
  logic m_tvalid;
  logic m_tready = 1'b0;
  logic [OUT_W-1:0] m_tdata;
  logic cfg_we = 1'b0;
  logic [CADDR_W-1:0] cfg_addr = '0;
  logic [DATA_W-1:0] cfg_wdata = '0;

  collide_checker board = new();
  int burst_left = 0;
  int ready_mode = 0;
  logic [7:0] ready_bits = 8'hFF;
  int cyc = 0;

  lbm_d2q5_reaction_collide #(
    .FRAC_BITS(FRAC_BITS)
  ) i_dut (
    .clk(clk),
    .rst(rst),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata(s_tdata),
    .s_tuser(s_tuser),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata(m_tdata),
    .cfg_we(cfg_we),
    .cfg_addr(cfg_addr),
    .cfg_wdata(cfg_wdata)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  initial begin
    #1_000_000;
    $display("RESULT: ERROR");
    $finish;
  end

  always @(posedge clk) begin
    if (!rst && s_tvalid && s_tready) board.note_node(node_t'(s_tdata), s_tuser);
    if (!rst && m_tvalid && m_tready) board.check_word(m_tdata);
  end

  always @(posedge clk) begin
    if (cyc % 96 == 0) begin
      ready_mode = $urandom_range(0, 3);
      ready_bits = $urandom;
    end
    cyc = cyc + 1;
    case (ready_mode)
      0: m_tready <= 1'b1;
      1: m_tready <= ($urandom_range(0, 3) != 0);
      2: m_tready <= ready_bits[cyc % 8];
      default: m_tready <= ($urandom_range(0, 1) != 0);
    endcase
  end

  task automatic send_node(input node_t n, input logic [1:0] ct);
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      if ($urandom_range(0, 3) != 0) begin
        s_tvalid <= 1'b0;
        repeat ($urandom_range(1, 10)) @(posedge clk);
      end
    end
    burst_left--;
    s_tdata <= n;
    s_tuser <= ct;
    s_tvalid <= 1'b1;
    do @(posedge clk); while (!s_tready);
  endtask

  task automatic drain();
    s_tvalid <= 1'b0;
    while (board.pending_nodes.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_regs(input logic [31:0] vals[5]);
    for (int k = 0; k < 5; k++) begin
      cfg_we <= 1'b1;
      cfg_addr <= cfg_idx_t'(k);
      cfg_wdata <= vals[k];
      @(posedge clk);
      board.set_reg(cfg_idx_t'(k), vals[k]);
    end
    cfg_we <= 1'b0;
  endtask

  function automatic node_t mk(logic [31:0] r, logic [31:0] e, logic [31:0] nn,
                               logic [31:0] w, logic [31:0] s, logic [31:0] vx,
                               logic [31:0] vy, logic [31:0] it);
    node_t n;
    n.rest = r;
    n.east = e;
    n.north = nn;
    n.west = w;
    n.south = s;
    n.vel_x = vx;
    n.vel_y = vy;
    n.iteration = it;
    return n;
  endfunction

  function automatic logic [31:0] pick_extreme();
    case ($urandom_range(0, 5))
      0: return 32'h7FFF_FFFF;
      1: return 32'h8000_0000;
      2: return 32'h0000_0000;
      3: return 32'hFFFF_FFFF;
      4: return ONE;
      default: return $urandom;
    endcase
  endfunction

  function automatic node_t random_node();
    node_t n;
    int mode;
    mode = $urandom_range(0, 9);
    if (mode < 6) begin
      n = mk($urandom_range(0, ONE / 2), $urandom_range(0, ONE / 2),
             $urandom_range(0, ONE / 2), $urandom_range(0, ONE / 2),
             $urandom_range(0, ONE / 2),
             int'($urandom_range(0, 2 * VMAX)) - VMAX,
             int'($urandom_range(0, 2 * VMAX)) - VMAX, 0);
    end else if (mode < 8) begin
      n = mk($urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom, 0);
    end else if (mode == 8) begin
      n = mk(pick_extreme(), pick_extreme(), pick_extreme(), pick_extreme(),
             pick_extreme(), pick_extreme(), pick_extreme(), 0);
    end else begin
      n = mk($urandom | 32'h4000_0000, $urandom | 32'h4000_0000,
             $urandom | 32'h4000_0000, $urandom | 32'h4000_0000,
             $urandom | 32'h4000_0000, $urandom, $urandom, 0);
    end
    if ($urandom_range(0, 1) != 0)
      n.iteration = board.switch_off_time + 32'($urandom_range(0, 6)) - 32'd3;
    else
      n.iteration = $urandom;
    return n;
  endfunction

  initial begin
    logic [31:0] vals[5];
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    send_node(mk(0, 0, 0, 0, 0, 0, 0, 0), CT_PLAIN);
    send_node(mk(32'h0555_5555, 32'h0555_5555, 32'h0555_5555, 32'h0555_5555,
                 32'h0555_5555, 32'h0200_0000, 32'hFE00_0000, 10), CT_OTHER);
    send_node(mk(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                 32'h7FFF_FFFF, 0, 0, 0), CT_CELL);
    send_node(mk(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                 32'h8000_0000, 0, 0, 0), CT_SOURCE);
    send_node(mk(ONE, ONE, ONE, ONE, ONE, 32'h7FFF_FFFF, 32'h8000_0000, 0), CT_OTHER);
    send_node(mk(ONE, ONE, ONE, ONE, ONE, 32'h8000_0000, 32'h7FFF_FFFF, 4999), CT_SOURCE);
    send_node(mk(ONE, ONE, ONE, ONE, ONE, 0, 0, 5000), CT_SOURCE);
    send_node(mk(ONE, ONE, ONE, ONE, ONE, 0, 0, 32'hFFFF_FFFF), CT_SOURCE);
    send_node(mk(ONE, ONE, ONE, ONE, ONE, 0, 0, 0), CT_CELL);
    send_node(mk(32'h7FFF_FFFF, 0, 0, 0, 0, 0, 0, 7), CT_PLAIN);
    send_node(mk(32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000,
                 32'h7FFF_FFFF, 0, 0, 3), CT_CELL);
    send_node(mk(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF), CT_OTHER);
    send_node(mk(32'h4000_0000, 32'h4000_0000, 32'h4000_0000, 32'h4000_0000,
                 32'h4000_0000, 32'h0800_0000, 32'hF800_0000, 1), CT_SOURCE);
    send_node(mk(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                 32'h7FFF_FFFF, 32'h2000_0000, 32'hE000_0000, 9), CT_PLAIN);
    send_node(mk(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                 32'h8000_0000, 32'h2000_0000, 32'hE000_0000, 9), CT_CELL);
    send_node(mk(32'hF000_0000, 32'hF000_0000, 32'hF000_0000, 32'hF000_0000,
                 32'hF000_0000, 32'h0100_0000, 32'hFF00_0000, 4999), CT_SOURCE);
    repeat (70) send_node(random_node(), $urandom_range(0, 3));
    drain();

    for (int p = 1; p <= 5; p++) begin
      case (p)
        1: vals = '{0, 0, 0, 0, 0};
        2: vals = '{32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                    32'h7FFF_FFFF};
        3: vals = '{$urandom_range(ONE / 4, 2 * ONE), $urandom_range(0, 1000),
                    $urandom_range(0, ONE / 16), $urandom_range(0, ONE / 16),
                    $urandom_range(0, ONE / 16)};
        4: vals = '{$urandom, $urandom, $urandom, $urandom, $urandom};
        default: vals = '{ONE + $urandom_range(0, ONE / 2), $urandom,
                          $urandom_range(0, ONE / 64), $urandom_range(0, ONE / 64),
                          $urandom_range(0, ONE / 64)};
      endcase
      write_regs(vals);
      repeat (92) send_node(random_node(), $urandom_range(0, 3));
      drain();
    end

    if (board.errors == 0)
      $display("RESULT: OK");
    else
      $display("RESULT: ERROR");
    $finish;
  end

endmodule
